// ===== sv/bti_pkg.sv =====
package bti_pkg;

    localparam int COORD_BITS       = 16;
    localparam int WEIGHT_FRAC_BITS = 16;
    localparam int WEIGHT_BITS      = WEIGHT_FRAC_BITS + 4;
    localparam int VIN_BITS         = 16;
    localparam int VOUT_BITS        = 24;

    // Exact widths of the intermediate terms.
    localparam int DIFF_W  = COORD_BITS + 1;
    localparam int PROD_W  = DIFF_W + COORD_BITS;
    localparam int AREA_W  = PROD_W + 2;
    localparam int NUM_W   = AREA_W + 2;
    localparam int WNUM_W  = NUM_W + WEIGHT_FRAC_BITS;
    localparam int VPROD_W = NUM_W + VIN_BITS;
    localparam int ACC_W   = VPROD_W + 2;
    localparam int DIV_QB  = ((WEIGHT_BITS > VOUT_BITS) ? WEIGHT_BITS : VOUT_BITS) + 1;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] px;
        logic signed [COORD_BITS-1:0] py;
        logic signed [COORD_BITS-1:0] v0_x;
        logic signed [COORD_BITS-1:0] v0_y;
        logic signed [COORD_BITS-1:0] v1_x;
        logic signed [COORD_BITS-1:0] v1_y;
        logic signed [COORD_BITS-1:0] v2_x;
        logic signed [COORD_BITS-1:0] v2_y;
        logic signed [VIN_BITS-1:0]   value0;
        logic signed [VIN_BITS-1:0]   value1;
        logic signed [VIN_BITS-1:0]   value2;
    } t_bti_req;

    typedef struct packed {
        logic signed [WEIGHT_BITS-1:0] weight0;
        logic signed [WEIGHT_BITS-1:0] weight1;
        logic signed [WEIGHT_BITS-1:0] weight2;
        logic signed [VOUT_BITS-1:0]   value_out;
        logic                          degenerate;
    } t_bti_res;

    typedef struct packed {
        logic signed [NUM_W-1:0]    den;
        logic signed [NUM_W-1:0]    n0;
        logic signed [NUM_W-1:0]    n1;
        logic signed [NUM_W-1:0]    n2;
        logic                       deg;
        logic signed [VIN_BITS-1:0] val0;
        logic signed [VIN_BITS-1:0] val1;
        logic signed [VIN_BITS-1:0] val2;
    } t_bti_geo;

    typedef struct packed {
        logic signed [NUM_W-1:0]  den;
        logic signed [WNUM_W-1:0] wn0;
        logic signed [WNUM_W-1:0] wn1;
        logic signed [WNUM_W-1:0] wn2;
        logic signed [ACC_W-1:0]  acc;
        logic                     deg;
    } t_bti_mix;

endpackage

// ===== sv/bti_geom.sv =====
module bti_geom (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  bti_pkg::t_bti_req i_req,
    output logic              o_vld,
    output bti_pkg::t_bti_geo o_geo
);

    localparam int DW = bti_pkg::DIFF_W;
    localparam int PW = bti_pkg::PROD_W;
    localparam int AW = bti_pkg::AREA_W;
    localparam int NW = bti_pkg::NUM_W;
    localparam int CB = bti_pkg::COORD_BITS;
    localparam int VB = bti_pkg::VIN_BITS;

    logic r_vld1, r_vld2, r_vld3, r_vld4;

    // Stage 1: coordinate differences.
    logic signed [DW-1:0] r_d12, r_d20, r_d01, r_d2p, r_dp1, r_d1p, r_dp0;
    logic signed [CB-1:0] r_py1, r_y0_1, r_y1_1, r_y2_1;
    logic signed [VB-1:0] r_a0_1, r_a1_1, r_a2_1;

    // Stage 2: products.
    logic signed [PW-1:0] r_pd0, r_pd1, r_pd2, r_pa0, r_pa1, r_pa2, r_pb0, r_pb1, r_pb2;
    logic signed [VB-1:0] r_a0_2, r_a1_2, r_a2_2;

    // Stage 3: twice the area and the two outer numerators.
    logic signed [AW-1:0] r_den3, r_n0_3, r_n2_3;
    logic signed [VB-1:0] r_a0_3, r_a1_3, r_a2_3;

    bti_pkg::t_bti_geo r_geo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
        end else begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
            r_vld3 <= r_vld2;
            r_vld4 <= r_vld3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d12  <= DW'(i_req.v1_x) - DW'(i_req.v2_x);
        r_d20  <= DW'(i_req.v2_x) - DW'(i_req.v0_x);
        r_d01  <= DW'(i_req.v0_x) - DW'(i_req.v1_x);
        r_d2p  <= DW'(i_req.v2_x) - DW'(i_req.px);
        r_dp1  <= DW'(i_req.px)   - DW'(i_req.v1_x);
        r_d1p  <= DW'(i_req.v1_x) - DW'(i_req.px);
        r_dp0  <= DW'(i_req.px)   - DW'(i_req.v0_x);
        r_py1  <= i_req.py;
        r_y0_1 <= i_req.v0_y;
        r_y1_1 <= i_req.v1_y;
        r_y2_1 <= i_req.v2_y;
        r_a0_1 <= i_req.value0;
        r_a1_1 <= i_req.value1;
        r_a2_1 <= i_req.value2;

        r_pd0  <= r_d12 * r_y0_1;
        r_pd1  <= r_d20 * r_y1_1;
        r_pd2  <= r_d01 * r_y2_1;
        r_pa0  <= r_d12 * r_py1;
        r_pa1  <= r_d2p * r_y1_1;
        r_pa2  <= r_dp1 * r_y2_1;
        r_pb0  <= r_d01 * r_py1;
        r_pb1  <= r_d1p * r_y0_1;
        r_pb2  <= r_dp0 * r_y1_1;
        r_a0_2 <= r_a0_1;
        r_a1_2 <= r_a1_1;
        r_a2_2 <= r_a2_1;

        r_den3 <= AW'(r_pd0) + AW'(r_pd1) + AW'(r_pd2);
        r_n0_3 <= AW'(r_pa0) + AW'(r_pa1) + AW'(r_pa2);
        r_n2_3 <= AW'(r_pb0) + AW'(r_pb1) + AW'(r_pb2);
        r_a0_3 <= r_a0_2;
        r_a1_3 <= r_a1_2;
        r_a2_3 <= r_a2_2;

        r_geo.den  <= NW'(r_den3);
        r_geo.n0   <= NW'(r_n0_3);
        r_geo.n2   <= NW'(r_n2_3);
        r_geo.n1   <= NW'(r_den3) - NW'(r_n0_3) - NW'(r_n2_3);
        r_geo.deg  <= (r_den3 == '0);
        r_geo.val0 <= r_a0_3;
        r_geo.val1 <= r_a1_3;
        r_geo.val2 <= r_a2_3;
    end

    assign o_vld = r_vld4;
    assign o_geo = r_geo;

endmodule

// ===== sv/bti_mix.sv =====
module bti_mix (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  bti_pkg::t_bti_geo i_geo,
    output logic              o_vld,
    output bti_pkg::t_bti_mix o_mix
);

    localparam int WW = bti_pkg::WNUM_W;
    localparam int VW = bti_pkg::VPROD_W;
    localparam int AC = bti_pkg::ACC_W;
    localparam int NW = bti_pkg::NUM_W;

    logic r_vld1, r_vld2;

    logic signed [VW-1:0] r_vp0, r_vp1, r_vp2;
    logic signed [WW-1:0] r_wn0, r_wn1, r_wn2;
    logic signed [NW-1:0] r_den1;
    logic                 r_deg1;

    bti_pkg::t_bti_mix r_mix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_vp0  <= i_geo.n0 * i_geo.val0;
        r_vp1  <= i_geo.n1 * i_geo.val1;
        r_vp2  <= i_geo.n2 * i_geo.val2;
        r_wn0  <= WW'(i_geo.n0) <<< bti_pkg::WEIGHT_FRAC_BITS;
        r_wn1  <= WW'(i_geo.n1) <<< bti_pkg::WEIGHT_FRAC_BITS;
        r_wn2  <= WW'(i_geo.n2) <<< bti_pkg::WEIGHT_FRAC_BITS;
        r_den1 <= i_geo.den;
        r_deg1 <= i_geo.deg;

        r_mix.acc <= AC'(r_vp0) + AC'(r_vp1) + AC'(r_vp2);
        r_mix.wn0 <= r_wn0;
        r_mix.wn1 <= r_wn1;
        r_mix.wn2 <= r_wn2;
        r_mix.den <= r_den1;
        r_mix.deg <= r_deg1;
    end

    assign o_vld = r_vld2;
    assign o_mix = r_mix;

endmodule

// ===== sv/bti_div.sv =====
module bti_div #(
    parameter int NUM_W = bti_pkg::WNUM_W,
    parameter int DEN_W = bti_pkg::NUM_W,
    parameter int OUT_W = bti_pkg::WEIGHT_BITS,
    parameter int QB    = bti_pkg::DIV_QB
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_vld,
    input  logic                    i_zero,
    input  logic signed [NUM_W-1:0] i_num,
    input  logic signed [DEN_W-1:0] i_den,
    output logic                    o_vld,
    output logic                    o_zero,
    output logic signed [OUT_W-1:0] o_quo
);

    localparam int RW = NUM_W + 1;
    localparam int CW = (RW > DEN_W + QB) ? RW : DEN_W + QB;
    localparam int NS = QB + 1;
    localparam logic [QB-1:0] LIM = QB'(1) << (OUT_W - 1);

    logic [RW-1:0]    n_num_x, n_num_mag;
    logic [DEN_W:0]   n_den_x, n_den_mag;

    logic [CW-1:0]    r_rem [0:NS];
    logic [DEN_W-1:0] r_den [0:NS];
    logic [QB-1:0]    r_q   [0:NS];
    logic             r_vld [0:NS];
    logic             r_neg [0:NS];
    logic             r_ovf [0:NS];
    logic             r_zro [0:NS];

    logic [QB-1:0]    n_rnd;
    logic [QB:0]      n_rnd_x;
    logic [OUT_W-1:0] n_quo;
    logic [OUT_W-1:0] r_quo;
    logic             r_o_vld, r_o_zero;

    always_comb begin
        n_num_x   = {i_num[NUM_W-1], i_num};
        n_num_mag = n_num_x[RW-1] ? (~n_num_x + 1'b1) : n_num_x;
        n_den_x   = {i_den[DEN_W-1], i_den};
        n_den_mag = n_den_x[DEN_W] ? (~n_den_x + 1'b1) : n_den_x;
    end

    // Front stage: magnitudes, with the numerator doubled so that the last
    // quotient bit is the rounding bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0] <= CW'({n_num_mag[NUM_W-1:0], 1'b0});
        r_den[0] <= n_den_mag[DEN_W-1:0];
        r_q[0]   <= '0;
        r_neg[0] <= i_num[NUM_W-1] ^ i_den[DEN_W-1];
        r_ovf[0] <= 1'b0;
        r_zro[0] <= i_zero;
    end

    // One quotient bit per stage; the first stage only checks for overflow.
    for (genvar j = 1; j <= NS; j++) begin : g_stage
        localparam int S = NS - j;
        logic [CW-1:0] n_dsh;
        logic          n_ge;

        always_comb begin
            n_dsh = CW'(r_den[j-1]) << S;
            n_ge  = (r_rem[j-1] >= n_dsh);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else begin
                r_vld[j] <= r_vld[j-1];
            end
        end

        if (S == QB) begin : g_ovf
            always_ff @(posedge i_clk) begin
                r_rem[j] <= r_rem[j-1];
                r_q[j]   <= r_q[j-1];
                r_ovf[j] <= n_ge;
            end
        end else begin : g_bit
            always_ff @(posedge i_clk) begin
                r_rem[j] <= n_ge ? (r_rem[j-1] - n_dsh) : r_rem[j-1];
                r_q[j]   <= r_q[j-1] | (QB'(n_ge) << S);
                r_ovf[j] <= r_ovf[j-1];
            end
        end

        always_ff @(posedge i_clk) begin
            r_den[j] <= r_den[j-1];
            r_neg[j] <= r_neg[j-1];
            r_zro[j] <= r_zro[j-1];
        end
    end

    always_comb begin
        n_rnd_x = ({1'b0, r_q[NS]} + (QB+1)'(1)) >> 1;
        n_rnd   = n_rnd_x[QB-1:0];
        if (r_zro[NS]) begin
            n_quo = '0;
        end else if (r_neg[NS]) begin
            if (r_ovf[NS] || (n_rnd > LIM)) begin
                n_quo = {1'b1, {(OUT_W-1){1'b0}}};
            end else begin
                n_quo = ~n_rnd[OUT_W-1:0] + 1'b1;
            end
        end else begin
            if (r_ovf[NS] || (n_rnd > LIM - 1'b1)) begin
                n_quo = {1'b0, {(OUT_W-1){1'b1}}};
            end else begin
                n_quo = n_rnd[OUT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else begin
            r_o_vld <= r_vld[NS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo    <= n_quo;
        r_o_zero <= r_zro[NS];
    end

    assign o_vld  = r_o_vld;
    assign o_zero = r_o_zero;
    assign o_quo  = r_quo;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_vld |-> ##(QB+3) o_vld)
        else $error("divider result did not emerge after the pipeline latency");

    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_vld && i_zero) |-> ##(QB+3) (o_zero && (o_quo == '0)))
        else $error("degenerate request did not produce a zero quotient");

endmodule

// ===== sv/barycentric_triangle_interpolator_unit.sv =====
// Barycentric interpolator: one request may be started in every clock cycle and
// busy is never raised. Each request yields exactly one result, marked by a
// single-cycle o_valid strobe; the receiver must take it then, since there is
// no back-pressure. The four restoring dividers, which resolve one quotient
// bit per pipeline stage, sit behind six stages of products and sums. A
// zero-area triangle sets degenerate and zeroes the rest.
module barycentric_triangle_interpolator_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  bti_pkg::t_bti_req i_req,
    output logic              busy,
    output logic              o_valid,
    output bti_pkg::t_bti_res o_res
);

    localparam int LAT = 6 + bti_pkg::DIV_QB + 3;

    logic              geo_vld, mix_vld;
    bti_pkg::t_bti_geo geo;
    bti_pkg::t_bti_mix mix;

    logic d0_vld, d1_vld, d2_vld, d3_vld;
    logic d0_zero, d1_zero, d2_zero, d3_zero;
    logic signed [bti_pkg::WEIGHT_BITS-1:0] w0, w1, w2;
    logic signed [bti_pkg::VOUT_BITS-1:0]   vout;

    assign busy = 1'b0;

    bti_geom u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (start),
        .i_req   (i_req),
        .o_vld   (geo_vld),
        .o_geo   (geo)
    );

    bti_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (geo_vld),
        .i_geo   (geo),
        .o_vld   (mix_vld),
        .o_mix   (mix)
    );

    bti_div #(
        .NUM_W (bti_pkg::WNUM_W),
        .DEN_W (bti_pkg::NUM_W),
        .OUT_W (bti_pkg::WEIGHT_BITS),
        .QB    (bti_pkg::DIV_QB)
    ) u_div_w0 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_vld (mix_vld), .i_zero (mix.deg),
        .i_num (mix.wn0), .i_den (mix.den),
        .o_vld (d0_vld), .o_zero (d0_zero), .o_quo (w0)
    );

    bti_div #(
        .NUM_W (bti_pkg::WNUM_W),
        .DEN_W (bti_pkg::NUM_W),
        .OUT_W (bti_pkg::WEIGHT_BITS),
        .QB    (bti_pkg::DIV_QB)
    ) u_div_w1 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_vld (mix_vld), .i_zero (mix.deg),
        .i_num (mix.wn1), .i_den (mix.den),
        .o_vld (d1_vld), .o_zero (d1_zero), .o_quo (w1)
    );

    bti_div #(
        .NUM_W (bti_pkg::WNUM_W),
        .DEN_W (bti_pkg::NUM_W),
        .OUT_W (bti_pkg::WEIGHT_BITS),
        .QB    (bti_pkg::DIV_QB)
    ) u_div_w2 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_vld (mix_vld), .i_zero (mix.deg),
        .i_num (mix.wn2), .i_den (mix.den),
        .o_vld (d2_vld), .o_zero (d2_zero), .o_quo (w2)
    );

    bti_div #(
        .NUM_W (bti_pkg::ACC_W),
        .DEN_W (bti_pkg::NUM_W),
        .OUT_W (bti_pkg::VOUT_BITS),
        .QB    (bti_pkg::DIV_QB)
    ) u_div_val (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_vld (mix_vld), .i_zero (mix.deg),
        .i_num (mix.acc), .i_den (mix.den),
        .o_vld (d3_vld), .o_zero (d3_zero), .o_quo (vout)
    );

    always_comb begin
        o_valid          = d0_vld & d1_vld & d2_vld & d3_vld;
        o_res.weight0    = w0;
        o_res.weight1    = w1;
        o_res.weight2    = w2;
        o_res.value_out  = vout;
        o_res.degenerate = d0_zero & d1_zero & d2_zero & d3_zero;
    end

    a_end_to_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##LAT o_valid)
        else $error("started request produced no result after the pipeline latency");

    // The datapath is not reset, so the zero flags are only compared while a
    // result is actually leaving the dividers.
    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (d0_vld == d3_vld) && (!d0_vld || (d0_zero == d3_zero)))
        else $error("weight and value dividers fell out of step");

endmodule
